[rtl/mlpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_pkg
// Operation and status codes of the multi-level priority queue.
// ----------------------------------------------------------------------------
package mlpq_pkg;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_SEARCH = 2'd3
  } mlpq_mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } mlpq_status_e;

endpackage

[rtl/multi_level_priority_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_level_priority_queue_top
// Strict-priority queue, one FIFO per level, entries held in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   An operation transfers when start is high and busy is low. mode selects
//   push, pop, peek or search; priority_req_i picks the level for a push
//   (saturated into 1..NUM_LEVELS), entry_id_i is the id or search key.
//   Each operation gives one result, shown for a single cycle with done_o.
//   The receiver cannot stall; busy stays high until the result is issued,
//   and a new operation may transfer in the cycle done_o is high.
// Steps, transfer to done_o:
//   push, failed pop/peek: S_EXEC. pop/peek: S_EXEC, S_RDWAIT (one memory read).
//   search: S_EXEC, then S_SEARCH walks the stored entries level by level; it
//   reads one entry per cycle within a level through the single memory port.
// Reset:
//   All levels empty. The entry memory is not cleared; only slots holding a
//   stored entry are ever read.
// ----------------------------------------------------------------------------
module multi_level_priority_queue_top #(
  parameter int NUM_LEVELS  = 4,
  parameter int LEVEL_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [2:0]  priority_req_i,
  input  logic [31:0] entry_id_i,
  input  logic [31:0] entry_data_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] head_id_o,
  output logic [31:0] head_data_o,
  output logic [2:0]  head_priority_o,
  output logic        found_o,
  output logic        is_empty_o,
  output logic [6:0]  total_count_o
);

  localparam int StoreSize = NUM_LEVELS * LEVEL_DEPTH;
  localparam int LvlW      = $clog2(NUM_LEVELS);
  localparam int PtrW      = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CntW      = $clog2(LEVEL_DEPTH + 1);
  localparam int AddrW     = $clog2(StoreSize);
  localparam int TotW      = $clog2(StoreSize + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_RDWAIT = 4'b0100,
    S_SEARCH = 4'b1000
  } state_e;

  function automatic logic [AddrW-1:0] slot_addr(input logic [LvlW-1:0] lv,
                                                 input logic [PtrW-1:0] p);
    slot_addr = AddrW'(lv) * AddrW'(LEVEL_DEPTH) + AddrW'(p);
  endfunction

  function automatic logic [PtrW-1:0] next_pos(input logic [PtrW-1:0] p);
    next_pos = (p == PtrW'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // entry memory: {id, data}
  logic [63:0]      mem_q [StoreSize];
  logic [63:0]      rdata_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_addr;

  state_e state_q, state_d;

  logic [PtrW-1:0] head_q  [NUM_LEVELS];
  logic [PtrW-1:0] head_d  [NUM_LEVELS];
  logic [PtrW-1:0] tail_q  [NUM_LEVELS];
  logic [PtrW-1:0] tail_d  [NUM_LEVELS];
  logic [CntW-1:0] count_q [NUM_LEVELS];
  logic [CntW-1:0] count_d [NUM_LEVELS];
  logic [TotW-1:0] total_q, total_d;
  logic            done_q, done_d;

  // search walk
  logic [LvlW-1:0] s_lv_q, s_lv_d;
  logic [CntW-1:0] s_k_q, s_k_d;
  logic [PtrW-1:0] s_p_q, s_p_d;
  logic            s_pend_q, s_pend_d;
  logic            s_done_q, s_done_d;
  logic            s_hit_q, s_hit_d;

  // operation and result payload
  mlpq_pkg::mlpq_mode_e   mode_q;
  logic [2:0]             prio_q;
  logic [31:0]            id_q, data_q;
  mlpq_pkg::mlpq_status_e status_q, status_d;
  logic [31:0]            hid_q, hid_d, hdata_q, hdata_d;
  logic [2:0]             hprio_q, hprio_d;
  logic                   found_q, found_d;

  logic [LvlW-1:0] push_lv, top_lv;
  logic            any_nz;
  logic            hit;

  always_comb begin
    if (prio_q == 3'd0) begin
      push_lv = '0;
    end else if (32'(prio_q) > NUM_LEVELS) begin
      push_lv = LvlW'(NUM_LEVELS - 1);
    end else begin
      push_lv = LvlW'(prio_q - 3'd1);
    end
  end

  always_comb begin
    top_lv = '0;
    any_nz = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (count_q[i] != '0) begin
        top_lv = LvlW'(i);
        any_nz = 1'b1;
      end
    end
  end

  assign hit = s_pend_q && (rdata_q[63:32] == id_q);

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    total_d  = total_q;
    done_d   = 1'b0;
    s_lv_d   = s_lv_q;
    s_k_d    = s_k_q;
    s_p_d    = s_p_q;
    s_pend_d = s_pend_q;
    s_done_d = s_done_q;
    s_hit_d  = s_hit_q;
    status_d = status_q;
    hid_d    = hid_q;
    hdata_d  = hdata_q;
    hprio_d  = hprio_q;
    found_d  = found_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        status_d = mlpq_pkg::ST_OK;
        hid_d    = '0;
        hdata_d  = '0;
        hprio_d  = '0;
        found_d  = 1'b0;
        unique case (mode_q)
          mlpq_pkg::MODE_PUSH: begin
            if (count_q[push_lv] == CntW'(LEVEL_DEPTH)) begin
              status_d = mlpq_pkg::ST_FULL;
            end else begin
              mem_we           = 1'b1;
              mem_addr         = slot_addr(push_lv, tail_q[push_lv]);
              tail_d[push_lv]  = next_pos(tail_q[push_lv]);
              count_d[push_lv] = count_q[push_lv] + 1'b1;
              total_d          = total_q + 1'b1;
            end
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          mlpq_pkg::MODE_POP, mlpq_pkg::MODE_PEEK: begin
            if (!any_nz) begin
              status_d = mlpq_pkg::ST_EMPTY;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else begin
              mem_re   = 1'b1;
              mem_addr = slot_addr(top_lv, head_q[top_lv]);
              hprio_d  = 3'(32'(top_lv) + 1);
              if (mode_q == mlpq_pkg::MODE_POP) begin
                head_d[top_lv]  = next_pos(head_q[top_lv]);
                count_d[top_lv] = count_q[top_lv] - 1'b1;
                total_d         = total_q - 1'b1;
              end
              state_d = S_RDWAIT;
            end
          end
          mlpq_pkg::MODE_SEARCH: begin
            s_lv_d   = LvlW'(NUM_LEVELS - 1);
            s_k_d    = '0;
            s_p_d    = head_q[LvlW'(NUM_LEVELS - 1)];
            s_pend_d = 1'b0;
            s_done_d = 1'b0;
            s_hit_d  = 1'b0;
            state_d  = S_SEARCH;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_RDWAIT: begin
        hid_d   = rdata_q[63:32];
        hdata_d = rdata_q[31:0];
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_SEARCH: begin
        s_hit_d  = s_hit_q | hit;
        s_pend_d = 1'b0;
        if (!s_done_q) begin
          if (s_k_q < count_q[s_lv_q]) begin
            mem_re   = 1'b1;
            mem_addr = slot_addr(s_lv_q, s_p_q);
            s_pend_d = 1'b1;
            s_k_d    = s_k_q + 1'b1;
            s_p_d    = next_pos(s_p_q);
          end else if (s_lv_q == '0) begin
            s_done_d = 1'b1;
          end else begin
            s_lv_d = s_lv_q - 1'b1;
            s_k_d  = '0;
            s_p_d  = head_q[s_lv_q - 1'b1];
          end
        end else if (!s_pend_q) begin
          found_d = s_hit_q;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      total_q  <= '0;
      done_q   <= 1'b0;
      s_lv_q   <= '0;
      s_k_q    <= '0;
      s_p_q    <= '0;
      s_pend_q <= 1'b0;
      s_done_q <= 1'b0;
      s_hit_q  <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      done_q   <= done_d;
      s_lv_q   <= s_lv_d;
      s_k_q    <= s_k_d;
      s_p_q    <= s_p_d;
      s_pend_q <= s_pend_d;
      s_done_q <= s_done_d;
      s_hit_q  <= s_hit_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      mode_q <= mlpq_pkg::mlpq_mode_e'(mode_i);
      prio_q <= priority_req_i;
      id_q   <= entry_id_i;
      data_q <= entry_data_i;
    end
    status_q <= status_d;
    hid_q    <= hid_d;
    hdata_q  <= hdata_d;
    hprio_q  <= hprio_d;
    found_q  <= found_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= {id_q, data_q};
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign head_id_o       = hid_q;
  assign head_data_o     = hdata_q;
  assign head_priority_o = hprio_q;
  assign found_o         = found_q;
  assign is_empty_o      = (total_q == '0);
  assign total_count_o   = 7'(total_q);

endmodule

[verif/multi_level_priority_queue_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_level_priority_queue_top_tb
// Self-checking bench for the multi-level priority queue. A behavioral queue
// model, one FIFO per level, predicts every result. Each result is compared
// field by field. Directed tests cover the empty queue, priority saturation,
// search and draining. Random bursts then alternate between filling and
// draining, so that levels reach full and wrap around.
// ----------------------------------------------------------------------------
module multi_level_priority_queue_top_tb;

  localparam int NUM_LEVELS  = 4;
  localparam int LEVEL_DEPTH = 16;
  localparam int RANDOM_OPS  = 1580;
  localparam int IDLE_LIMIT  = 4000;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] data;
  } entry_t;

  typedef struct packed {
    mlpq_pkg::mlpq_status_e status;
    logic [31:0]            head_id;
    logic [31:0]            head_data;
    logic [2:0]             head_prio;
    logic                   found;
    logic                   is_empty;
    logic [6:0]             total;
  } op_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  mode_i;
  logic [2:0]  priority_req_i;
  logic [31:0] entry_id_i;
  logic [31:0] entry_data_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] head_id_o;
  logic [31:0] head_data_o;
  logic [2:0]  head_priority_o;
  logic        found_o;
  logic        is_empty_o;
  logic [6:0]  total_count_o;

  entry_t     level_fifo[NUM_LEVELS][$];
  op_result_t expected_results[$];
  op_result_t oldest;
  int         mismatches = 0;
  int         idle_cycles = 0;
  bit         no_gaps = 1'b0;

  multi_level_priority_queue_top #(
    .NUM_LEVELS (NUM_LEVELS),
    .LEVEL_DEPTH(LEVEL_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .priority_req_i (priority_req_i),
    .entry_id_i     (entry_id_i),
    .entry_data_i   (entry_data_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .head_id_o      (head_id_o),
    .head_data_o    (head_data_o),
    .head_priority_o(head_priority_o),
    .found_o        (found_o),
    .is_empty_o     (is_empty_o),
    .total_count_o  (total_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Applies one operation to the queue model and returns its result.
  function automatic op_result_t apply_op(mlpq_pkg::mlpq_mode_e op, logic [2:0] prio,
                                          logic [31:0] id, logic [31:0] data);
    op_result_t r;
    entry_t     e;
    int         lv;
    int         top;
    int         count;
    r = '0;
    r.status = mlpq_pkg::ST_OK;
    top = -1;
    for (lv = NUM_LEVELS - 1; lv >= 0; lv--)
      if (top < 0 && level_fifo[lv].size() != 0) top = lv;
    case (op)
      mlpq_pkg::MODE_PUSH: begin
        if (prio == 0) lv = 0;
        else if (prio > NUM_LEVELS) lv = NUM_LEVELS - 1;
        else lv = prio - 1;
        if (level_fifo[lv].size() >= LEVEL_DEPTH) begin
          r.status = mlpq_pkg::ST_FULL;
        end else begin
          e.id = id;
          e.data = data;
          level_fifo[lv].push_back(e);
        end
      end
      mlpq_pkg::MODE_POP, mlpq_pkg::MODE_PEEK: begin
        if (top < 0) begin
          r.status = mlpq_pkg::ST_EMPTY;
        end else begin
          e = level_fifo[top][0];
          r.head_id = e.id;
          r.head_data = e.data;
          r.head_prio = 3'(top + 1);
          if (op == mlpq_pkg::MODE_POP) void'(level_fifo[top].pop_front());
        end
      end
      default: begin
        for (lv = 0; lv < NUM_LEVELS; lv++)
          for (int k = 0; k < level_fifo[lv].size(); k++)
            if (level_fifo[lv][k].id == id) r.found = 1'b1;
      end
    endcase
    count = 0;
    for (lv = 0; lv < NUM_LEVELS; lv++) count += level_fifo[lv].size();
    r.total = 7'(count);
    r.is_empty = (count == 0);
    return r;
  endfunction

  // Ids from a small pool collide often, which makes search hits likely.
  function automatic logic [31:0] pick_id();
    if ($urandom_range(3) == 0) return $urandom_range(15);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_key();
    int lv;
    lv = $urandom_range(NUM_LEVELS - 1);
    if ($urandom_range(1) == 1 && level_fifo[lv].size() != 0)
      return level_fifo[lv][$urandom_range(level_fifo[lv].size() - 1)].id;
    return pick_id();
  endfunction

  // Called at a rising edge; returns at the edge where the operation transfers.
  task automatic send_op(mlpq_pkg::mlpq_mode_e op, logic [2:0] prio, logic [31:0] id,
                         logic [31:0] data);
    if (!no_gaps && $urandom_range(99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start          <= 1'b1;
    mode_i         <= op;
    priority_req_i <= prio;
    entry_id_i     <= id;
    entry_data_i   <= data;
    do @(posedge clk_i); while (busy);
    expected_results.push_back(apply_op(op, prio, id, data));
  endtask

  task automatic test_empty_queue();
    send_op(mlpq_pkg::MODE_POP, 3'd1, 32'h0, 32'h0);
    send_op(mlpq_pkg::MODE_PEEK, 3'd4, 32'hffff_ffff, 32'hffff_ffff);
    send_op(mlpq_pkg::MODE_SEARCH, 3'd0, 32'h0, 32'h0);
  endtask

  task automatic test_priority_saturation();
    send_op(mlpq_pkg::MODE_PUSH, 3'd0, 32'h0000_0000, 32'hffff_ffff);
    send_op(mlpq_pkg::MODE_PUSH, 3'd7, 32'hffff_ffff, 32'h0000_0000);
    send_op(mlpq_pkg::MODE_PUSH, 3'd5, $urandom, $urandom);
    send_op(mlpq_pkg::MODE_PUSH, 3'd1, $urandom, $urandom);
    send_op(mlpq_pkg::MODE_PUSH, 3'd2, $urandom, $urandom);
    send_op(mlpq_pkg::MODE_PUSH, 3'd3, $urandom, $urandom);
    send_op(mlpq_pkg::MODE_PUSH, 3'd4, $urandom, $urandom);
    send_op(mlpq_pkg::MODE_PUSH, 3'd3, $urandom, $urandom);
  endtask

  task automatic test_search();
    send_op(mlpq_pkg::MODE_SEARCH, 3'd0, 32'hffff_ffff, $urandom);
    send_op(mlpq_pkg::MODE_SEARCH, 3'd7, 32'h5a5a_5a5a, $urandom);
    send_op(mlpq_pkg::MODE_PEEK, 3'd0, $urandom, $urandom);
  endtask

  task automatic test_drain();
    repeat (10) send_op(mlpq_pkg::MODE_POP, 3'($urandom_range(7)), $urandom, $urandom);
  endtask

  // Bursts alternate between filling and draining the queue.
  task automatic test_random(int n_ops);
    int  sent;
    int  burst;
    int  push_pct;
    int  pick;
    bit  filling;
    sent = 0;
    filling = 1'b1;
    while (sent < n_ops) begin
      burst = $urandom_range(40, 120);
      push_pct = filling ? 70 : 25;
      filling = !filling;
      repeat (burst) begin
        no_gaps = (sent >= 500 && sent < 800);
        pick = $urandom_range(99);
        if (pick < push_pct) begin
          send_op(mlpq_pkg::MODE_PUSH,
                  ($urandom_range(99) < 85) ? 3'($urandom_range(1, NUM_LEVELS))
                                            : 3'($urandom_range(7)),
                  pick_id(), $urandom);
        end else begin
          pick = $urandom_range(99);
          if (pick < 45)
            send_op(mlpq_pkg::MODE_POP, 3'($urandom_range(7)), $urandom, $urandom);
          else if (pick < 65)
            send_op(mlpq_pkg::MODE_PEEK, 3'($urandom_range(7)), $urandom, $urandom);
          else
            send_op(mlpq_pkg::MODE_SEARCH, 3'($urandom_range(7)), pick_key(), $urandom);
        end
        sent++;
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with no operation pending", $time);
      end else begin
        oldest = expected_results.pop_front();
        check_field("status", 32'(oldest.status), 32'(status_o));
        check_field("head_id", oldest.head_id, head_id_o);
        check_field("head_data", oldest.head_data, head_data_o);
        check_field("head_priority", 32'(oldest.head_prio), 32'(head_priority_o));
        check_field("found", 32'(oldest.found), 32'(found_o));
        check_field("is_empty", 32'(oldest.is_empty), 32'(is_empty_o));
        check_field("total_count", 32'(oldest.total), 32'(total_count_o));
      end
    end
  end

  // Watchdog: cycles with neither an input transfer nor a result.
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    mode_i         <= mlpq_pkg::MODE_PUSH;
    priority_req_i <= '0;
    entry_id_i     <= '0;
    entry_data_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_queue();
    test_priority_saturation();
    test_search();
    test_drain();
    test_random(RANDOM_OPS);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mlpq_pkg.sv
rtl/multi_level_priority_queue_top.sv
verif/multi_level_priority_queue_top_tb.sv
